@@ design/bfmc_pkg.sv @@
// Package for the buffer frame manager: result kinds, error codes, request types.
// No dependencies.
package bfmc_pkg;
    localparam int unsigned DEF_NUM_FRAMES = 16;
    localparam int unsigned MAX_RESULTS    = 16;
    localparam logic [15:0] PAGE_BYTES_RST = 16'd4096;

    localparam logic [1:0] REQ_PIN       = 2'd0;
    localparam logic [1:0] REQ_UNPIN     = 2'd1;
    localparam logic [1:0] REQ_UNPIN_ALL = 2'd2;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;

    localparam logic [1:0] KIND_GRANT = 2'd0;
    localparam logic [1:0] KIND_WB    = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NO_STREAM = 2'd1;
    localparam logic [1:0] ERR_NO_FRAME  = 2'd2;
    localparam logic [1:0] ERR_NOT_PIN   = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  frame_index;
        logic [7:0]  out_stream;
        logic [31:0] out_page;
        logic [15:0] byte_count;
        logic        was_hit;
        logic        need_read;
        logic [1:0]  error_code;
        logic        last;
    } result_t;
endpackage

@@ design/bfmc_out_reg.sv @@
// Output register of the result channel: one stage holding a result.
// Depends on bfmc_pkg.
module bfmc_out_reg import bfmc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t din,
    output logic    full,
    input  logic    pop,
    output result_t dout
);
    logic    full_reg;
    result_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (push) begin
            full_reg <= 1'b1;
        end else if (pop) begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= din;
        end
    end

    assign full = full_reg;
    assign dout = data_reg;
endmodule

@@ design/buffer_frame_manager_clock.sv @@
// Top level of the buffer frame manager with clock replacement.
// Depends on bfmc_pkg and bfmc_out_reg.
//
// One request at a time. A sequencer walks the frame table one frame per cycle
// through a single shared compare unit. A pin or unpin passes through the lookup
// of every frame, then a step that updates the frame, then the loading of each
// result into the output register; a write-back result comes before the final
// one. A pin miss adds the sweep, one frame per cycle, in which the first
// revolution clears the reference bit of every eligible frame it meets; the
// sweep reports no frame when a whole revolution finds none eligible, and a
// dirty victim first loads its write-back. Unpin-all scans every frame, loads
// the final result at the end, and for every other write-back loads it, then
// revisits the frame. A stalled m_ready holds each result longer. A pin or
// unpin of stream zero, or a request of unknown type, goes from idle straight
// to loading its result. s_ready is high only while the sequencer idles and no
// page-size write is offered. Frame table lives in flops.
module buffer_frame_manager_clock import bfmc_pkg::*; #(
    parameter int unsigned NUM_FRAMES = DEF_NUM_FRAMES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_stream_id,
    input  logic [31:0] s_page_number,
    input  logic        s_read_from_device,
    input  logic        s_mark_dirty,
    input  logic signed [16:0] s_new_size,
    input  logic        s_force_write,
    input  logic        s_mem_pages_free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_frame_index,
    output logic [7:0]  m_out_stream,
    output logic [31:0] m_out_page,
    output logic [15:0] m_byte_count,
    output logic        m_was_hit,
    output logic        m_need_read,
    output logic [1:0]  m_error_code,
    output logic        m_last
);
    localparam int unsigned FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int unsigned RW = $clog2(NUM_FRAMES + 3);
    localparam int unsigned KW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOOK  = 7'b0000010,
        ST_SWEEP = 7'b0000100,
        ST_FILL  = 7'b0001000,
        ST_UNPIN = 7'b0010000,
        ST_ALL   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg;
    logic [15:0] page_bytes_reg;

    logic            fv_reg [NUM_FRAMES];
    logic [7:0]      fs_reg [NUM_FRAMES];
    logic [31:0]     fp_reg [NUM_FRAMES];
    logic [7:0]      fpin_reg [NUM_FRAMES];
    logic            fd_reg [NUM_FRAMES];
    logic            fr_reg [NUM_FRAMES];
    logic            fm_reg [NUM_FRAMES];
    logic [15:0]     fb_reg [NUM_FRAMES];
    logic [FW-1:0]   hand_reg;

    // latched request
    logic [1:0]  rt_reg;
    logic [7:0]  rs_reg;
    logic [31:0] rp_reg;
    logic        rrd_reg, rmd_reg, rfw_reg, rmf_reg;
    logic [16:0] rsz_reg;

    logic [FW-1:0] idx_reg;      // scan index
    logic [FW:0]   step_reg;     // steps within one hand round
    logic [RW-1:0] round_reg;
    logic [FW-1:0] hit_reg;
    logic          found_reg;
    logic [KW-1:0] cnt_reg;      // unpin-all results emitted
    logic          wbpend_reg;   // unpin-all: a write-back waits to be marked last

    // pending result to load and whether it finishes the request
    result_t res_reg;
    logic    res_final_reg;

    logic    push;
    logic    ofull;
    result_t odata;

    bfmc_out_reg u_out (
        .aclk(aclk), .aresetn(aresetn), .push(push), .din(res_reg),
        .full(ofull), .pop(m_ready), .dout(odata)
    );

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_valid   = ofull;
    assign push      = (state_reg == ST_EMIT) && (!ofull || m_ready);
    assign m_kind = odata.kind;
    assign m_frame_index = odata.frame_index;
    assign m_out_stream = odata.out_stream;
    assign m_out_page = odata.out_page;
    assign m_byte_count = odata.byte_count;
    assign m_was_hit = odata.was_hit;
    assign m_need_read = odata.need_read;
    assign m_error_code = odata.error_code;
    assign m_last = odata.last;

    // shared compare unit on the frame under the scan index
    logic          match;
    logic [FW-1:0] hnext;
    logic          elig;
    assign match = fv_reg[idx_reg] && fs_reg[idx_reg] == rs_reg
                   && fp_reg[idx_reg] == rp_reg;
    assign hnext = (hand_reg == FW'(NUM_FRAMES - 1)) ? '0 : hand_reg + 1'b1;
    assign elig = rmf_reg ? (!fv_reg[hnext] || fpin_reg[hnext] == 8'd0)
                          : (fv_reg[hnext] && fpin_reg[hnext] == 8'd0 && fm_reg[hnext]);

    function automatic result_t mk_err(logic [1:0] code);
        result_t r;
        r = '0;
        r.kind = KIND_ERR;
        r.error_code = code;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic result_t mk_done0();
        result_t r;
        r = '0;
        r.kind = KIND_DONE;
        r.last = 1'b1;
        return r;
    endfunction

    logic last_idx;
    assign last_idx = (idx_reg == FW'(NUM_FRAMES - 1));

    // unpin-all: frame under the scan index belongs to the request / needs a write-back
    logic all_sel;
    logic all_wb;
    assign all_sel = fv_reg[idx_reg] && (rs_reg == 8'd0 || fs_reg[idx_reg] == rs_reg);
    assign all_wb  = all_sel && (fd_reg[idx_reg] || rmd_reg) && cnt_reg != KW'(MAX_RESULTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            page_bytes_reg <= PAGE_BYTES_RST;
            hand_reg <= FW'(NUM_FRAMES - 1);
            for (int i = 0; i < NUM_FRAMES; i++) begin
                fv_reg[i] <= 1'b0; fpin_reg[i] <= '0; fd_reg[i] <= 1'b0;
                fr_reg[i] <= 1'b0; fm_reg[i] <= 1'b0; fb_reg[i] <= '0;
            end
            res_final_reg <= 1'b0;
            wbpend_reg <= 1'b0;
        end else begin
            case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    page_bytes_reg <= cfg_data;
                end else if (s_valid) begin
                    rt_reg <= s_req_type; rs_reg <= s_stream_id;
                    rp_reg <= s_page_number; rrd_reg <= s_read_from_device;
                    rmd_reg <= s_mark_dirty; rfw_reg <= s_force_write;
                    rmf_reg <= s_mem_pages_free; rsz_reg <= s_new_size;
                    idx_reg <= '0; found_reg <= 1'b0; cnt_reg <= '0;
                    wbpend_reg <= 1'b0;
                    if (s_req_type == REQ_UNPIN_ALL) begin
                        state_reg <= ST_ALL;
                    end else if (s_req_type == REQ_PIN || s_req_type == REQ_UNPIN) begin
                        if (s_stream_id == 8'd0) begin
                            res_reg <= mk_err(ERR_NO_STREAM);
                            res_final_reg <= 1'b1;
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_LOOK;
                        end
                    end else begin
                        res_reg <= mk_done0();
                        res_final_reg <= 1'b1;
                        state_reg <= ST_EMIT;
                    end
                end
            end
            ST_LOOK: begin
                // first match wins
                if (match && !found_reg) begin
                    found_reg <= 1'b1;
                    hit_reg <= idx_reg;
                end
                idx_reg <= idx_reg + 1'b1;
                if (last_idx) begin
                    if (rt_reg == REQ_PIN) begin
                        if (found_reg || match) begin
                            state_reg <= ST_FILL;
                        end else begin
                            step_reg <= '0; round_reg <= '0;
                            state_reg <= ST_SWEEP;
                        end
                    end else begin
                        state_reg <= ST_UNPIN;
                    end
                end
            end
            ST_SWEEP: begin
                // advance hand one frame per cycle
                hand_reg <= hnext;
                if (elig) begin
                    step_reg <= '0;
                    if (!fv_reg[hnext]) begin
                        hit_reg <= hnext; state_reg <= ST_FILL;
                    end else if (fr_reg[hnext]) begin
                        fr_reg[hnext] <= 1'b0;
                        if (round_reg == RW'(NUM_FRAMES + 1)) begin
                            res_reg <= mk_err(ERR_NO_FRAME);
                            res_final_reg <= 1'b1;
                            state_reg <= ST_EMIT;
                        end
                        round_reg <= round_reg + 1'b1;
                    end else begin
                        hit_reg <= hnext;
                        if (fd_reg[hnext]) begin
                            fd_reg[hnext] <= 1'b0;
                            res_reg <= '{KIND_WB, 4'(hnext), fs_reg[hnext], fp_reg[hnext],
                                         fb_reg[hnext], 1'b0, 1'b0, ERR_NONE, 1'b0};
                            res_final_reg <= 1'b0;
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_FILL;
                        end
                    end
                end else if (step_reg == (FW+1)'(NUM_FRAMES - 1)) begin
                    res_reg <= mk_err(ERR_NO_FRAME);
                    res_final_reg <= 1'b1;
                    state_reg <= ST_EMIT;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            ST_FILL: begin
                if (!found_reg) begin
                    fv_reg[hit_reg] <= 1'b1; fs_reg[hit_reg] <= rs_reg;
                    fp_reg[hit_reg] <= rp_reg; fpin_reg[hit_reg] <= 8'd1;
                    fd_reg[hit_reg] <= 1'b0;
                end else if (fpin_reg[hit_reg] != 8'hFF) begin
                    fpin_reg[hit_reg] <= fpin_reg[hit_reg] + 1'b1;
                end
                fr_reg[hit_reg] <= 1'b1;
                res_final_reg <= 1'b1;
                state_reg <= ST_EMIT;
                if (!fm_reg[hit_reg]) begin
                    if (!rmf_reg) begin
                        res_reg <= mk_err(ERR_NO_FRAME);
                    end else begin
                        fm_reg[hit_reg] <= 1'b1;
                        fb_reg[hit_reg] <= page_bytes_reg;
                        res_reg <= '{KIND_GRANT, 4'(hit_reg), rs_reg, rp_reg,
                                     page_bytes_reg, found_reg, rrd_reg, ERR_NONE, 1'b1};
                    end
                end else begin
                    res_reg <= '{KIND_GRANT, 4'(hit_reg), rs_reg, rp_reg,
                                 fb_reg[hit_reg], found_reg, rrd_reg, ERR_NONE, 1'b1};
                end
            end
            ST_UNPIN: begin
                state_reg <= ST_EMIT;
                if (!found_reg || fpin_reg[hit_reg] == 8'd0) begin
                    res_reg <= mk_err(ERR_NOT_PIN);
                    res_final_reg <= 1'b1;
                end else begin
                    logic        dnew;
                    logic [15:0] bnew;
                    dnew = fd_reg[hit_reg] | rmd_reg;
                    bnew = rsz_reg[16] ? fb_reg[hit_reg] : rsz_reg[15:0];
                    fb_reg[hit_reg] <= bnew;
                    fpin_reg[hit_reg] <= fpin_reg[hit_reg] - 1'b1;
                    if (fpin_reg[hit_reg] == 8'd1 && dnew && rfw_reg) begin
                        fd_reg[hit_reg] <= 1'b0;
                        res_reg <= '{KIND_WB, 4'(hit_reg), fs_reg[hit_reg],
                                     fp_reg[hit_reg], bnew, 1'b0, 1'b0, ERR_NONE, 1'b0};
                        res_final_reg <= 1'b0;
                    end else begin
                        fd_reg[hit_reg] <= dnew;
                        res_reg <= '{KIND_DONE, 4'(hit_reg), rs_reg, rp_reg, bnew,
                                     1'b0, 1'b0, ERR_NONE, 1'b1};
                        res_final_reg <= 1'b1;
                    end
                end
            end
            ST_ALL: begin
                // hold a found write-back until the next one (or the end) decides last
                if (all_wb && wbpend_reg) begin
                    // emit the held one first, then revisit this frame
                    res_final_reg <= 1'b0;
                    wbpend_reg <= 1'b0;
                    state_reg <= ST_EMIT;
                end else begin
                    if (all_sel) begin
                        fv_reg[idx_reg] <= 1'b0; fpin_reg[idx_reg] <= '0;
                        fd_reg[idx_reg] <= 1'b0; fr_reg[idx_reg] <= 1'b0;
                        fm_reg[idx_reg] <= 1'b0; fb_reg[idx_reg] <= '0;
                    end
                    if (all_wb) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        res_reg <= '{KIND_WB, 4'(idx_reg), fs_reg[idx_reg],
                                     fp_reg[idx_reg], fb_reg[idx_reg], 1'b0, 1'b0,
                                     ERR_NONE, last_idx};
                        wbpend_reg <= 1'b1;
                    end else if (last_idx) begin
                        if (wbpend_reg) begin
                            res_reg.last <= 1'b1;
                        end else begin
                            res_reg <= mk_done0();
                        end
                    end
                    if (last_idx) begin
                        res_final_reg <= 1'b1;
                        state_reg <= ST_EMIT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (push) begin
                    if (res_final_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (rt_reg == REQ_PIN) begin
                        state_reg <= ST_FILL;
                    end else if (rt_reg == REQ_UNPIN) begin
                        res_reg <= '{KIND_DONE, 4'(hit_reg), rs_reg, rp_reg,
                                     fb_reg[hit_reg], 1'b0, 1'b0, ERR_NONE, 1'b1};
                        res_final_reg <= 1'b1;
                    end else begin
                        // resume unpin-all at the same frame, nothing pending
                        state_reg <= ST_ALL;
                    end
                end
            end
            default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // result pushed only when the output stage can take it
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && ofull) |-> m_ready) else $error("output overrun");
    // request taken only while idle
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (state_reg == ST_IDLE)) else $error("accept while busy");
    // a final result returns the sequencer to idle
    a_final_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && res_final_reg) |=> (state_reg == ST_IDLE)) else $error("no return to idle");
`endif
endmodule

@@ sim/bfmc_checker.sv @@
// Checker for the buffer frame manager: watches the request, config and result
// channels, predicts results with its own frame table, compares each result as a whole.
// Depends on bfmc_pkg.
module bfmc_checker import bfmc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [7:0]         s_stream_id,
    input  logic [31:0]        s_page_number,
    input  logic               s_read_from_device,
    input  logic               s_mark_dirty,
    input  logic signed [16:0] s_new_size,
    input  logic               s_force_write,
    input  logic               s_mem_pages_free,
    input  logic               m_valid,
    input  logic               m_ready,
    input  result_t            m_result,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NF = DEF_NUM_FRAMES;

    logic        fr_valid [NF];
    logic [7:0]  fr_stream [NF];
    logic [31:0] fr_page [NF];
    logic [7:0]  fr_pins [NF];
    logic        fr_dirty [NF];
    logic        fr_ref [NF];
    logic        fr_mem [NF];
    logic [15:0] fr_bytes [NF];
    logic [3:0]  hand;
    logic [15:0] page_size;

    result_t expected_results [$];

    assign pending = expected_results.size();

    function automatic result_t mk(logic [1:0] kind, int f, logic [7:0] st, logic [31:0] pg,
                                   logic [15:0] b, logic hit, logic rd, logic [1:0] err,
                                   logic lst);
        result_t r;
        r.kind = kind; r.frame_index = f[3:0]; r.out_stream = st; r.out_page = pg;
        r.byte_count = b; r.was_hit = hit; r.need_read = rd; r.error_code = err;
        r.last = lst;
        return r;
    endfunction

    function automatic result_t writeback(int f, logic lst);
        return mk(KIND_WB, f, fr_stream[f], fr_page[f], fr_bytes[f], 1'b0, 1'b0, ERR_NONE, lst);
    endfunction

    function automatic result_t err_result(logic [1:0] code);
        return mk(KIND_ERR, 0, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0, code, 1'b1);
    endfunction

    function automatic int find_frame(logic [7:0] s, logic [31:0] p);
        for (int i = 0; i < NF; i++)
            if (fr_valid[i] && fr_stream[i] == s && fr_page[i] == p) return i;
        return -1;
    endfunction

    function automatic bit can_evict(int f, bit mem_free);
        if (!mem_free) return fr_valid[f] && fr_pins[f] == 0 && fr_mem[f];
        return !fr_valid[f] || fr_pins[f] == 0;
    endfunction

    // Second-chance sweep; a dirty victim queues its write-back.
    function automatic int sweep_victim(bit mem_free);
        bit found;
        for (int round = 0; round <= NF + 1; round++) begin
            found = 0;
            for (int i = 0; i < NF; i++) begin
                hand = hand + 4'd1;
                if (can_evict(hand, mem_free)) begin
                    found = 1;
                    break;
                end
            end
            if (!found) return -1;
            if (!fr_valid[hand]) return hand;
            if (fr_ref[hand]) begin
                fr_ref[hand] = 0;
                continue;
            end
            if (fr_dirty[hand]) begin
                expected_results.push_back(writeback(hand, 1'b0));
                fr_dirty[hand] = 0;
            end
            return hand;
        end
        return -1;
    endfunction

    task automatic predict_pin();
        int f;
        bit hit;
        if (s_stream_id == 0) begin
            expected_results.push_back(err_result(ERR_NO_STREAM));
            return;
        end
        f = find_frame(s_stream_id, s_page_number);
        hit = f >= 0;
        if (hit) begin
            if (fr_pins[f] != 8'd255) fr_pins[f]++;
        end else begin
            f = sweep_victim(s_mem_pages_free);
            if (f < 0) begin
                expected_results.push_back(err_result(ERR_NO_FRAME));
                return;
            end
            fr_valid[f] = 1; fr_stream[f] = s_stream_id; fr_page[f] = s_page_number;
            fr_pins[f] = 1; fr_dirty[f] = 0;
        end
        fr_ref[f] = 1;
        if (!fr_mem[f]) begin
            if (!s_mem_pages_free) begin
                expected_results.push_back(err_result(ERR_NO_FRAME));
                return;
            end
            fr_mem[f] = 1;
            fr_bytes[f] = page_size;
        end
        expected_results.push_back(mk(KIND_GRANT, f, s_stream_id, s_page_number, fr_bytes[f],
                                      hit, s_read_from_device, ERR_NONE, 1'b1));
    endtask

    task automatic predict_unpin();
        int f;
        if (s_stream_id == 0) begin
            expected_results.push_back(err_result(ERR_NO_STREAM));
            return;
        end
        f = find_frame(s_stream_id, s_page_number);
        if (f < 0 || fr_pins[f] == 0) begin
            expected_results.push_back(err_result(ERR_NOT_PIN));
            return;
        end
        if (s_mark_dirty) fr_dirty[f] = 1;
        if (!s_new_size[16]) fr_bytes[f] = s_new_size[15:0];
        if (fr_pins[f] == 1 && fr_dirty[f] && s_force_write) begin
            expected_results.push_back(writeback(f, 1'b0));
            fr_dirty[f] = 0;
        end
        fr_pins[f]--;
        expected_results.push_back(mk(KIND_DONE, f, s_stream_id, s_page_number, fr_bytes[f],
                                      1'b0, 1'b0, ERR_NONE, 1'b1));
    endtask

    task automatic predict_unpin_all();
        int n;
        result_t r;
        n = 0;
        for (int f = 0; f < NF; f++) begin
            if (!fr_valid[f] || (s_stream_id != 0 && fr_stream[f] != s_stream_id)) continue;
            if ((fr_dirty[f] || s_mark_dirty) && n < MAX_RESULTS) begin
                expected_results.push_back(writeback(f, 1'b0));
                n++;
            end
            fr_valid[f] = 0; fr_pins[f] = 0; fr_dirty[f] = 0;
            fr_ref[f] = 0; fr_mem[f] = 0; fr_bytes[f] = 0;
        end
        if (n == 0) begin
            expected_results.push_back(mk(KIND_DONE, 0, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0,
                                          ERR_NONE, 1'b1));
        end else begin
            r = expected_results.pop_back();
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NF; i++) begin
                fr_valid[i] <= 0; fr_pins[i] <= 0; fr_dirty[i] <= 0;
                fr_ref[i] <= 0; fr_mem[i] <= 0; fr_bytes[i] <= 0;
                fr_stream[i] <= 0; fr_page[i] <= 0;
            end
            hand <= 4'(NF - 1);
            page_size <= PAGE_BYTES_RST;
            fail_count <= 0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) page_size = cfg_data;
            if (s_valid && s_ready) begin
                case (s_req_type)
                    REQ_PIN:       predict_pin();
                    REQ_UNPIN:     predict_unpin();
                    REQ_UNPIN_ALL: predict_unpin_all();
                    default: expected_results.push_back(mk(KIND_DONE, 0, 8'd0, 32'd0, 16'd0,
                                                           1'b0, 1'b0, ERR_NONE, 1'b1));
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %p", m_result);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== m_result) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, m_result);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ sim/tb.sv @@
// Testbench top for buffer_frame_manager_clock: drives requests and page-size
// writes, applies back-pressure, and reports the verdict. Depends on bfmc_pkg
// and bfmc_checker.
module tb;
    import bfmc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_req_type;
    logic [7:0]         s_stream_id;
    logic [31:0]        s_page_number;
    logic               s_read_from_device;
    logic               s_mark_dirty;
    logic signed [16:0] s_new_size;
    logic               s_force_write;
    logic               s_mem_pages_free;
    logic               m_valid;
    logic               m_ready;
    result_t            m_result;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    buffer_frame_manager_clock i_dut (
        .aclk, .aresetn,
        .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_req_type, .s_stream_id, .s_page_number,
        .s_read_from_device, .s_mark_dirty, .s_new_size, .s_force_write,
        .s_mem_pages_free,
        .m_valid, .m_ready,
        .m_kind(m_result.kind), .m_frame_index(m_result.frame_index),
        .m_out_stream(m_result.out_stream), .m_out_page(m_result.out_page),
        .m_byte_count(m_result.byte_count), .m_was_hit(m_result.was_hit),
        .m_need_read(m_result.need_read), .m_error_code(m_result.error_code),
        .m_last(m_result.last)
    );

    bfmc_checker i_checker (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_req_type, .s_stream_id, .s_page_number,
        .s_read_from_device, .s_mark_dirty, .s_new_size, .s_force_write,
        .s_mem_pages_free, .m_valid, .m_ready, .m_result,
        .fail_count, .pending
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel at the current rate, redrawn every cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end

    // Present one request and hold it until the block takes it. Valid stays
    // high afterwards so a back-to-back request needs no gap; drop it before
    // doing anything else.
    task automatic send_request(logic [1:0] rt, logic [7:0] st, logic [31:0] pg, logic rd,
                                logic dirty, logic signed [16:0] sz, logic fw, logic mem);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1; s_req_type <= rt; s_stream_id <= st; s_page_number <= pg;
        s_read_from_device <= rd; s_mark_dirty <= dirty; s_new_size <= sz;
        s_force_write <= fw; s_mem_pages_free <= mem;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drain all results, let the sequencer settle, then write page size.
    task automatic set_page_size(logic [15:0] v);
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        cfg_valid <= 1; cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    // Random request; pins and unpins reuse a small address pool so hits,
    // evictions and proper unpins are frequent.
    task automatic random_request();
        int pick;
        logic [1:0] rt;
        logic [7:0] st;
        logic [31:0] pg;
        logic signed [16:0] sz;
        pick = $urandom_range(99);
        rt = pick < 50 ? REQ_PIN : pick < 88 ? REQ_UNPIN : pick < 96 ? REQ_UNPIN_ALL
                                                                     : REQ_UNUSED;
        st = $urandom_range(99) < 90 ? 8'($urandom_range(1, 4)) : 8'($urandom);
        if ($urandom_range(99) < 4) st = 0;
        pg = $urandom_range(99) < 85 ? 32'($urandom_range(0, 7)) : $urandom;
        case ($urandom_range(3))
            0: sz = -17'sd1;
            1: sz = 17'($urandom);
            default: sz = 17'($urandom_range(0, 65535));
        endcase
        send_request(rt, st, pg, 1'($urandom_range(1)), 1'($urandom_range(1)), sz,
                     1'($urandom_range(1)), $urandom_range(99) < 80);
    endtask

    initial begin
        aresetn = 0;
        cfg_valid = 0; cfg_data = 0;
        s_valid = 0; s_req_type = REQ_PIN; s_stream_id = 0; s_page_number = 0;
        s_read_from_device = 0; s_mark_dirty = 0; s_new_size = 0;
        s_force_write = 0; s_mem_pages_free = 1;
        m_ready = 0;
        send_idle_pct = 37;
        recv_idle_pct = 54;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: stream zero, unpin of absent page, no-memory miss, hits,
        // forced write-back, size keep, unknown type.
        send_request(REQ_PIN, 8'd0, 32'd5, 1, 0, 0, 0, 1);
        send_request(REQ_UNPIN, 8'd0, 32'd5, 0, 0, 0, 0, 1);
        send_request(REQ_UNPIN, 8'd9, 32'd5, 0, 0, 0, 0, 1);
        send_request(REQ_PIN, 8'd1, 32'd0, 0, 0, 0, 0, 0);
        send_request(REQ_PIN, 8'hFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 1);
        send_request(REQ_PIN, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        send_request(REQ_UNPIN, 8'hFF, 32'hFFFF_FFFF, 0, 1, 17'sd65535, 0, 1);
        send_request(REQ_UNPIN, 8'hFF, 32'hFFFF_FFFF, 0, 1, -17'sd1, 1, 1);
        send_request(REQ_UNPIN, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 1, 1);
        send_request(REQ_PIN, 8'h2A, 32'h5555_AAAA, 1, 0, 0, 0, 1);
        send_request(REQ_UNPIN, 8'h2A, 32'h5555_AAAA, 0, 1, 17'sd0, 0, 1);
        send_request(REQ_UNUSED, 8'd3, 32'd3, 1, 1, -17'sd1, 1, 0);
        // Fill every frame pinned, then miss with and without free memory.
        for (int i = 0; i < 16; i++) send_request(REQ_PIN, 8'd7, 32'(i), 0, 0, 0, 0, 1);
        send_request(REQ_PIN, 8'd8, 32'd0, 0, 0, 0, 0, 1);
        send_request(REQ_PIN, 8'd8, 32'd0, 0, 0, 0, 0, 0);
        send_request(REQ_UNPIN_ALL, 8'd0, 32'd0, 0, 1, 0, 0, 1);
        send_request(REQ_UNPIN_ALL, 8'd0, 32'd0, 0, 0, 0, 0, 1);

        set_page_size(16'd1);
        for (int i = 0; i < 100; i++) random_request();
        set_page_size(16'hFFFF);
        send_idle_pct = 54;
        recv_idle_pct = 37;
        for (int i = 0; i < 100; i++) random_request();
        // Hold the sender until every expected result has come back.
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        set_page_size(16'($urandom_range(1, 65535)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 100; i++) random_request();

        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
